FILE: sv/ctfs_pkg.sv
// shared types, constants and codes of the cyclic time fraction sensor
package ctfs_pkg;

	localparam int TIME_BITS     = 48;
	localparam int FRACTION_BITS = 16;
	localparam int COUNT_BITS    = 32;

	localparam int FRAC_W        = FRACTION_BITS + 1;
	localparam int QUO_BITS      = TIME_BITS + FRACTION_BITS;
	localparam int DIV_CNT_BITS  = $clog2(QUO_BITS);
	localparam int CNT_SUM_BITS  = ((TIME_BITS > COUNT_BITS) ? TIME_BITS : COUNT_BITS) + 1;
	localparam int CFG_IDX_BITS  = 3;

	localparam int OUT_FIELD_BITS = FRAC_W + TIME_BITS + 5;
	localparam int OUT_BITS       = ((OUT_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_BITS   = OUT_BITS - OUT_FIELD_BITS;

	localparam logic [FRAC_W-1:0]     FRAC_ONE  = FRAC_W'(1) << FRACTION_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_START,
		REG_STOP_TIME,
		REG_PERIOD,
		REG_LOOP_ENABLE,
		REG_SENSOR_ENABLE,
		REG_X3D_RULES
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_FIN,
		ST_HOLD
	} state_t;

	typedef enum logic [2:0] {
		PS_NOW_ST,
		PS_SPAN_IV,
		PS_NOW_STOP,
		PS_ST_STOP,
		PS_NOW_BASE,
		PS_STOP_BASE
	} prep_step_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] start_at;
		logic [TIME_BITS-1:0] stop_time;
		logic [TIME_BITS-1:0] period;
		logic                 loop_enable;
		logic                 sensor_enable;
		logic                 x3d_rules;
	} cfg_t;

	typedef struct packed {
		logic                 done;
		logic [QUO_BITS-1:0]  quo;
		logic [TIME_BITS-1:0] rem;
	} div_res_t;

	// first member sits in the top bits of the packed word
	typedef struct packed {
		logic [OUT_PAD_BITS-1:0] pad;
		logic                    time_event;
		logic                    cycle_start_event;
		logic [TIME_BITS-1:0]    cycle_start;
		logic                    fraction_event;
		logic [FRAC_W-1:0]       fraction;
		logic                    active_changed;
		logic                    is_active;
	} result_t;

endpackage

FILE: sv/ctfs_div.sv
// bit-serial restoring divider, one quotient bit per cycle, fraction bits follow the integer part
module ctfs_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ctfs_pkg::TIME_BITS-1:0] dividend,
	input  logic [ctfs_pkg::TIME_BITS-1:0] divisor,
	output ctfs_pkg::div_res_t             res
);

	logic                              busy_q;
	logic                              done_q;
	logic [ctfs_pkg::DIV_CNT_BITS-1:0] cnt_q;
	logic [ctfs_pkg::TIME_BITS-1:0]    d_q;
	logic [ctfs_pkg::TIME_BITS-1:0]    r_q;
	logic [ctfs_pkg::TIME_BITS-1:0]    iv_q;
	logic [ctfs_pkg::QUO_BITS-1:0]     q_q;
	logic [ctfs_pkg::TIME_BITS-1:0]    rem_q;

	logic [ctfs_pkg::TIME_BITS:0]      shifted;
	logic [ctfs_pkg::TIME_BITS+1:0]    trial;
	logic                              take;
	logic [ctfs_pkg::TIME_BITS-1:0]    r_next;

	always_comb begin
		shifted = {r_q, d_q[ctfs_pkg::TIME_BITS-1]};
		trial   = {1'b0, shifted} - {2'b00, iv_q};
		take    = !trial[ctfs_pkg::TIME_BITS+1];
		r_next  = take ? trial[ctfs_pkg::TIME_BITS-1:0] : shifted[ctfs_pkg::TIME_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			d_q    <= '0;
			r_q    <= '0;
			iv_q   <= '0;
			q_q    <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				d_q    <= dividend;
				r_q    <= '0;
				iv_q   <= divisor;
			end else if (busy_q) begin
				r_q   <= r_next;
				d_q   <= {d_q[ctfs_pkg::TIME_BITS-2:0], 1'b0};
				q_q   <= {q_q[ctfs_pkg::QUO_BITS-2:0], take};
				cnt_q <= cnt_q + 1'b1;
				// remainder of the integer part, before the fraction bits
				if (cnt_q == ctfs_pkg::DIV_CNT_BITS'(ctfs_pkg::TIME_BITS - 1))
					rem_q <= r_next;
				if (cnt_q == ctfs_pkg::DIV_CNT_BITS'(ctfs_pkg::QUO_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res.done = done_q;
	assign res.quo  = q_q;
	assign res.rem  = rem_q;

endmodule

FILE: sv/ctfs_core.sv
// sensor state, tick sequencer with one shared subtractor, and the serial divider
module ctfs_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ctfs_pkg::cfg_t                 cfg,
	input  logic                           cfg_wr,
	input  logic                           in_valid,
	input  logic [ctfs_pkg::TIME_BITS-1:0] in_time,
	output logic                           in_ready,
	output logic                           res_valid,
	output ctfs_pkg::result_t              res,
	input  logic                           res_take
);

	ctfs_pkg::state_t              state_q;
	ctfs_pkg::prep_step_t          step_q;

	logic [ctfs_pkg::TIME_BITS-1:0]  now_q;
	logic                            was_active_q;
	logic                            active_q;
	logic                            relatch_q;
	logic [ctfs_pkg::COUNT_BITS-1:0] count_q;
	logic [ctfs_pkg::TIME_BITS-1:0]  lstart_q;
	logic [ctfs_pkg::TIME_BITS-1:0]  liv_q;
	logic [ctfs_pkg::FRAC_W-1:0]     lfrac_q;
	logic [ctfs_pkg::TIME_BITS-1:0]  lcs_q;
	logic [ctfs_pkg::TIME_BITS-1:0]  base_q;
	logic [ctfs_pkg::TIME_BITS-1:0]  tmp_q;
	logic [ctfs_pkg::TIME_BITS-1:0]  ct_q;
	logic                            lt_st_q;
	logic                            gt_st_q;
	logic                            ge_iv_q;
	logic                            ge_stop_q;
	logic                            stop_on_q;
	logic                            stop_path_q;
	logic                            use_div_q;
	logic                            fev_q;
	logic                            cse_q;
	logic                            tev_q;

	logic [ctfs_pkg::TIME_BITS-1:0]  op_a;
	logic [ctfs_pkg::TIME_BITS-1:0]  op_b;
	logic [ctfs_pkg::TIME_BITS:0]    sub;
	logic                            borrow;
	logic [ctfs_pkg::TIME_BITS-1:0]  dval;
	logic                            dnz;
	logic [ctfs_pkg::TIME_BITS-1:0]  base;

	logic                            no_act;
	logic                            stop_path_c;
	logic                            div_start;
	logic [ctfs_pkg::TIME_BITS-1:0]  div_dividend;
	ctfs_pkg::div_res_t              div_res;

	logic [ctfs_pkg::FRACTION_BITS-1:0] frac_raw;
	logic                               inc_nz;
	logic [ctfs_pkg::FRAC_W-1:0]        nf;
	logic [ctfs_pkg::FRAC_W-1:0]        nf_adj;
	logic [ctfs_pkg::CNT_SUM_BITS-1:0]  cnt_sum;
	logic                               cnt_sat;
	logic                               advance;

	assign base = active_q ? base_q : lstart_q;

	// operand selection for the shared subtractor
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			ctfs_pkg::ST_PREP: begin
				case (step_q)
					ctfs_pkg::PS_NOW_ST: begin
						op_a = now_q;
						op_b = lstart_q;
					end
					ctfs_pkg::PS_SPAN_IV: begin
						op_a = tmp_q;
						op_b = liv_q;
					end
					ctfs_pkg::PS_NOW_STOP: begin
						op_a = now_q;
						op_b = cfg.stop_time;
					end
					ctfs_pkg::PS_ST_STOP: begin
						op_a = lstart_q;
						op_b = cfg.stop_time;
					end
					ctfs_pkg::PS_NOW_BASE: begin
						op_a = now_q;
						op_b = base;
					end
					ctfs_pkg::PS_STOP_BASE: begin
						op_a = cfg.stop_time;
						op_b = base;
					end
					default: begin
						op_a = '0;
						op_b = '0;
					end
				endcase
			end
			ctfs_pkg::ST_FIN: begin
				op_a = now_q;
				op_b = div_res.rem;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_comb begin
		sub    = {1'b0, op_a} - {1'b0, op_b};
		borrow = sub[ctfs_pkg::TIME_BITS];
		dval   = sub[ctfs_pkg::TIME_BITS-1:0];
		dnz    = |dval;
	end

	// activation blocked: before start, at or past stop, or the no-loop x3d rules
	assign no_act = lt_st_q || (borrow && ge_stop_q) ||
		(cfg.x3d_rules && !cfg.loop_enable && ((lstart_q == '0) || ge_iv_q));

	assign stop_path_c  = active_q && stop_on_q && ge_stop_q;
	assign div_start    = (state_q == ctfs_pkg::ST_PREP) && (step_q == ctfs_pkg::PS_STOP_BASE) &&
		(stop_path_c ? (!borrow && dnz) : 1'b1);
	assign div_dividend = stop_path_c ? dval : ct_q;

	ctfs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (liv_q),
		.res      (div_res)
	);

	always_comb begin
		frac_raw = use_div_q ? div_res.quo[ctfs_pkg::FRACTION_BITS-1:0] : '0;
		inc_nz   = use_div_q && (|div_res.quo[ctfs_pkg::QUO_BITS-1:ctfs_pkg::FRACTION_BITS]);
		nf       = {1'b0, frac_raw};
		// a zero fraction past the start reads as a full cycle
		nf_adj   = ((frac_raw == '0) && gt_st_q) ? ctfs_pkg::FRAC_ONE : nf;
		cnt_sum  = ctfs_pkg::CNT_SUM_BITS'(div_res.quo[ctfs_pkg::QUO_BITS-1:ctfs_pkg::FRACTION_BITS])
			+ ctfs_pkg::CNT_SUM_BITS'(count_q);
		cnt_sat  = cnt_sum > ctfs_pkg::CNT_SUM_BITS'(ctfs_pkg::COUNT_MAX);
		advance  = cfg.loop_enable && inc_nz;
	end

	// start and interval are taken again at the first enabled tick after reset or after a write while inactive
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			relatch_q <= 1'b1;
		else if (cfg_wr && !active_q)
			relatch_q <= 1'b1;
		else if (in_valid && in_ready && cfg.sensor_enable)
			relatch_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ctfs_pkg::ST_IDLE;
			step_q       <= ctfs_pkg::PS_NOW_ST;
			now_q        <= '0;
			was_active_q <= 1'b0;
			active_q     <= 1'b0;
			count_q      <= '0;
			lstart_q     <= '0;
			liv_q        <= ctfs_pkg::TIME_BITS'(1);
			lfrac_q      <= '0;
			lcs_q        <= '0;
			base_q       <= '0;
			tmp_q        <= '0;
			ct_q         <= '0;
			lt_st_q      <= 1'b0;
			gt_st_q      <= 1'b0;
			ge_iv_q      <= 1'b0;
			ge_stop_q    <= 1'b0;
			stop_on_q    <= 1'b0;
			stop_path_q  <= 1'b0;
			use_div_q    <= 1'b0;
			fev_q        <= 1'b0;
			cse_q        <= 1'b0;
			tev_q        <= 1'b0;
		end else begin
			case (state_q)
				ctfs_pkg::ST_IDLE: begin
					if (in_valid) begin
						now_q        <= in_time;
						was_active_q <= active_q;
						fev_q        <= 1'b0;
						tev_q        <= 1'b0;
						cse_q        <= !cfg.sensor_enable && active_q;
						if (!cfg.sensor_enable) begin
							if (active_q) begin
								lcs_q    <= in_time;
								active_q <= 1'b0;
								count_q  <= '0;
							end
							state_q <= ctfs_pkg::ST_HOLD;
						end else begin
							if (relatch_q) begin
								lstart_q  <= cfg.start_at;
								liv_q     <= (cfg.period == '0) ?
									ctfs_pkg::TIME_BITS'(1) : cfg.period;
							end
							step_q  <= ctfs_pkg::PS_NOW_ST;
							state_q <= ctfs_pkg::ST_PREP;
						end
					end
				end
				ctfs_pkg::ST_PREP: begin
					step_q <= ctfs_pkg::prep_step_t'(step_q + 1'b1);
					case (step_q)
						ctfs_pkg::PS_NOW_ST: begin
							lt_st_q <= borrow;
							gt_st_q <= !borrow && dnz;
							tmp_q   <= dval;
						end
						ctfs_pkg::PS_SPAN_IV: ge_iv_q <= !borrow;
						ctfs_pkg::PS_NOW_STOP: ge_stop_q <= !borrow;
						ctfs_pkg::PS_ST_STOP: begin
							stop_on_q <= borrow;
							if (!active_q && no_act)
								state_q <= ctfs_pkg::ST_HOLD;
						end
						ctfs_pkg::PS_NOW_BASE: ct_q <= borrow ? '0 : dval;
						ctfs_pkg::PS_STOP_BASE: begin
							stop_path_q <= stop_path_c;
							use_div_q   <= div_start;
							state_q     <= div_start ? ctfs_pkg::ST_DIV : ctfs_pkg::ST_FIN;
						end
						default: state_q <= ctfs_pkg::ST_IDLE;
					endcase
				end
				ctfs_pkg::ST_DIV: begin
					if (div_res.done)
						state_q <= ctfs_pkg::ST_FIN;
				end
				ctfs_pkg::ST_FIN: begin
					state_q <= ctfs_pkg::ST_HOLD;
					if (stop_path_q) begin
						tev_q    <= 1'b1;
						fev_q    <= 1'b1;
						lfrac_q  <= (frac_raw == '0) ? ctfs_pkg::FRAC_ONE : nf;
						active_q <= 1'b0;
						count_q  <= '0;
					end else if (active_q && !cfg.loop_enable && inc_nz) begin
						// end of a single cycle
						tev_q    <= 1'b1;
						fev_q    <= 1'b1;
						lfrac_q  <= ctfs_pkg::FRAC_ONE;
						active_q <= 1'b0;
						count_q  <= '0;
					end else begin
						if (active_q) begin
							tev_q <= 1'b1;
							if (nf_adj != lfrac_q) begin
								lfrac_q <= nf_adj;
								fev_q   <= 1'b1;
							end
						end else begin
							active_q <= 1'b1;
							lfrac_q  <= nf;
							fev_q    <= 1'b1;
						end
						cse_q <= advance || !active_q;
						if (advance) begin
							count_q <= cnt_sat ? ctfs_pkg::COUNT_MAX :
								cnt_sum[ctfs_pkg::COUNT_BITS-1:0];
							base_q  <= dval;
							lcs_q   <= dval;
						end else if (!active_q) begin
							// a new run starts its first cycle at the latched start
							base_q <= lstart_q;
							lcs_q  <= now_q;
						end
					end
				end
				ctfs_pkg::ST_HOLD: begin
					if (res_take)
						state_q <= ctfs_pkg::ST_IDLE;
				end
				default: state_q <= ctfs_pkg::ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ctfs_pkg::ST_IDLE);
	assign res_valid = (state_q == ctfs_pkg::ST_HOLD);

	always_comb begin
		res                   = '0;
		res.is_active         = active_q;
		res.active_changed    = active_q != was_active_q;
		res.fraction          = lfrac_q;
		res.fraction_event    = fev_q;
		res.cycle_start       = lcs_q;
		res.cycle_start_event = cse_q;
		res.time_event        = tev_q;
	end

endmodule

FILE: sv/cyclic_time_fraction_sensor_unit.sv
// Cyclic time fraction sensor: one tick word in, one status word out. Ticks are handled one at a
// time. A disabled tick goes straight to the result, a tick that does not activate stops once the
// subtractor has compared the start with the stop time, a tick that reaches the stop time at or
// before the cycle start skips the divider, and any other tick takes six steps of the shared 48-bit
// subtractor, the bit-serial divider that yields whole cycles elapsed and the Q16 fraction in one
// pass, one more subtractor step and the load of the output register. A finished result sits in
// the output register so the next tick can be taken while it waits.
module cyclic_time_fraction_sensor_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ctfs_pkg::TIME_BITS-1:0]    s_tdata,   // current_time
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// is_active, active_changed, fraction, fraction_event, cycle_start, cycle_start_event,
	// time_event, zero pad
	output logic [ctfs_pkg::OUT_BITS-1:0]     m_tdata,
	input  logic                              cfg_wr_en,
	input  logic [ctfs_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [ctfs_pkg::TIME_BITS-1:0]    cfg_data
);

	ctfs_pkg::cfg_t    cfg_q;
	logic              cfg_hit;
	logic              res_valid;
	logic              res_take;
	ctfs_pkg::result_t res;
	logic              m_valid_q;
	ctfs_pkg::result_t m_word_q;

	always_comb begin
		case (ctfs_pkg::reg_idx_t'(cfg_index))
			ctfs_pkg::REG_START,
			ctfs_pkg::REG_STOP_TIME,
			ctfs_pkg::REG_PERIOD,
			ctfs_pkg::REG_LOOP_ENABLE,
			ctfs_pkg::REG_SENSOR_ENABLE,
			ctfs_pkg::REG_X3D_RULES: cfg_hit = cfg_wr_en;
			default:                 cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_at      <= '0;
			cfg_q.stop_time     <= '0;
			cfg_q.period        <= ctfs_pkg::TIME_BITS'(1);
			cfg_q.loop_enable   <= 1'b0;
			cfg_q.sensor_enable <= 1'b1;
			cfg_q.x3d_rules     <= 1'b0;
		end else if (cfg_wr_en) begin
			case (ctfs_pkg::reg_idx_t'(cfg_index))
				ctfs_pkg::REG_START:         cfg_q.start_at      <= cfg_data;
				ctfs_pkg::REG_STOP_TIME:     cfg_q.stop_time     <= cfg_data;
				ctfs_pkg::REG_PERIOD:        cfg_q.period        <= cfg_data;
				ctfs_pkg::REG_LOOP_ENABLE:   cfg_q.loop_enable   <= cfg_data[0];
				ctfs_pkg::REG_SENSOR_ENABLE: cfg_q.sensor_enable <= cfg_data[0];
				ctfs_pkg::REG_X3D_RULES:     cfg_q.x3d_rules     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ctfs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cfg_wr    (cfg_hit),
		.in_valid  (s_tvalid),
		.in_time   (s_tdata),
		.in_ready  (s_tready),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	// output register, loads when empty or being drained
	assign res_take = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_word_q  <= '0;
		end else if (res_take) begin
			m_valid_q <= res_valid;
			if (res_valid)
				m_word_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_word_q;

	a_one_tick_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("tick taken while another is in progress");

	a_change_has_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_word_q.active_changed |->
			(m_word_q.fraction_event || m_word_q.cycle_start_event))
		else $error("active flag changed without a fraction or cycle start event");

	a_time_echo_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_word_q.time_event && !m_word_q.is_active |-> m_word_q.active_changed)
		else $error("time echoed by a sensor that was not active");

	a_fraction_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_word_q.fraction <= ctfs_pkg::FRAC_ONE))
		else $error("fraction above one");

endmodule
